@@ src/tpla_pkg.sv @@
// Shared types, constants and the CORDIC angle table for the line fit angle block.
package tpla_pkg;

	localparam int MAX_DIM      = 4096;
	localparam int DIM_W        = 13;
	localparam int POS_W        = 12;
	localparam int CNT_W        = 25;
	localparam int SX_W         = 37;
	localparam int SXX_W        = 49;
	localparam int CFG_IDX_W    = 2;
	localparam int MUL_OP_W     = 49;
	localparam int MUL_STEPS    = 49;
	localparam int PROD_W       = 86;
	localparam int DIFF_W       = 87;
	localparam int NORM_BITS    = 30;
	localparam int XY_W         = 34;
	localparam int Z_W          = 26;
	localparam int ANG_W        = 22;
	localparam int STEP_W       = 5;
	localparam int CORDIC_STEPS = 16;
	localparam int OUT_W        = 15;
	localparam int LIMIT_Q7     = 11520;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RED_THRESHOLD = 2'd2;

	localparam logic [DIM_W-1:0] RST_FRAME_WIDTH   = 13'd640;
	localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT  = 13'd480;
	localparam logic [7:0]       RST_RED_THRESHOLD = 8'd200;

	// product selects for the determinant terms
	localparam logic [2:0] SEL_N_SXX  = 3'd0;
	localparam logic [2:0] SEL_SX_SX  = 3'd1;
	localparam logic [2:0] SEL_N_SXY  = 3'd2;
	localparam logic [2:0] SEL_SX_SY  = 3'd3;
	localparam logic [2:0] SEL_SX_SXY = 3'd4;
	localparam logic [2:0] SEL_SXX_SY = 3'd5;

	typedef struct packed {
		logic [CNT_W-1:0] hit;
		logic [SX_W-1:0]  sx;
		logic [SXX_W-1:0] sxx;
		logic [SX_W-1:0]  sy;
		logic [SXX_W-1:0] sxy;
	} tpla_sums_t;

	typedef struct packed {
		logic              mul_load;
		logic              mul_step;
		logic              commit;
		logic              prep;
		logic              norm_step;
		logic              cordic_load;
		logic              cordic_step;
		logic              emit;
		logic [2:0]        sel;
		logic [STEP_W-1:0] step;
	} tpla_cmd_t;

	typedef struct packed {
		logic d_zero;
		logic norm_done;
	} tpla_stat_t;

	// atan(2^-i) in degrees, 16 fraction bits
	function automatic logic [ANG_W-1:0] atan_q16(input logic [STEP_W-1:0] i);
		logic [ANG_W-1:0] a;
		begin
			unique case (i)
				5'd0:  a = 22'd2949120;
				5'd1:  a = 22'd1740967;
				5'd2:  a = 22'd919879;
				5'd3:  a = 22'd466945;
				5'd4:  a = 22'd234379;
				5'd5:  a = 22'd117304;
				5'd6:  a = 22'd58666;
				5'd7:  a = 22'd29335;
				5'd8:  a = 22'd14668;
				5'd9:  a = 22'd7334;
				5'd10: a = 22'd3667;
				5'd11: a = 22'd1833;
				5'd12: a = 22'd917;
				5'd13: a = 22'd458;
				5'd14: a = 22'd229;
				5'd15: a = 22'd115;
				5'd16: a = 22'd57;
				5'd17: a = 22'd29;
				5'd18: a = 22'd14;
				5'd19: a = 22'd7;
				5'd20: a = 22'd4;
				5'd21: a = 22'd2;
				5'd22: a = 22'd1;
				default: a = 22'd0;
			endcase
			return a;
		end
	endfunction

endpackage

@@ src/tpla_accum.sv @@
// Configuration registers, raster position tracking and per-pixel fit sums.
module tpla_accum import tpla_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic                 pix_valid,
	input  logic [7:0]           red,
	input  logic                 clear,
	output tpla_sums_t           sums,
	output logic                 frame_end
);

	logic [DIM_W-1:0] width_q, height_q;
	logic [7:0]       thresh_q;
	logic [POS_W-1:0] col_q, row_q;
	tpla_sums_t       sums_q;
	logic [DIM_W-1:0] w_eff, h_eff, y13;
	logic [POS_W-1:0] y_pos;
	logic             row_end, hit;
	logic [2*POS_W-1:0] xx, xy;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		begin
			if (v == '0)
				r = DIM_W'(1);
			else if (v > DIM_W'(MAX_DIM))
				r = DIM_W'(MAX_DIM);
			else
				r = v;
			return r;
		end
	endfunction

	always_comb begin
		w_eff   = eff_dim(width_q);
		h_eff   = eff_dim(height_q);
		y13     = h_eff - DIM_W'(1) - {1'b0, row_q};
		y_pos   = ({1'b0, row_q} < h_eff) ? y13[POS_W-1:0] : '0;
		row_end = ({1'b0, col_q} + DIM_W'(1)) >= w_eff;
		hit     = red >= thresh_q;
		xx      = col_q * col_q;
		xy      = col_q * y_pos;
		frame_end = pix_valid && row_end && (({1'b0, row_q} + DIM_W'(1)) >= h_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_FRAME_WIDTH;
			height_q <= RST_FRAME_HEIGHT;
			thresh_q <= RST_RED_THRESHOLD;
			col_q    <= '0;
			row_q    <= '0;
			sums_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FRAME_WIDTH:   width_q  <= cfg_data;
					REG_FRAME_HEIGHT:  height_q <= cfg_data;
					REG_RED_THRESHOLD: thresh_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (clear)
				sums_q <= '0;
			if (pix_valid) begin
				if (hit) begin
					sums_q.hit <= sums_q.hit + CNT_W'(1);
					sums_q.sx  <= sums_q.sx + SX_W'(col_q);
					sums_q.sxx <= sums_q.sxx + SXX_W'(xx);
					sums_q.sy  <= sums_q.sy + SX_W'(y_pos);
					sums_q.sxy <= sums_q.sxy + SXX_W'(xy);
				end
				if (row_end) begin
					col_q <= '0;
					row_q <= frame_end ? '0 : row_q + POS_W'(1);
				end else begin
					col_q <= col_q + POS_W'(1);
				end
			end
		end
	end

	assign sums = sums_q;

endmodule

@@ src/tpla_dp.sv @@
// Solve datapath: shift-add multiplier, determinant terms, normalizer and CORDIC.
module tpla_dp import tpla_pkg::*; (
	input  logic                   clk,
	input  tpla_sums_t             sums,
	input  tpla_cmd_t              cmd,
	output tpla_stat_t             stat,
	output logic signed [OUT_W-1:0] angle_deg_q7,
	output logic                   degenerate
);

	logic [MUL_OP_W-1:0] opa, opb, mb_q;
	logic [PROD_W-1:0]   ma_q, acc_q, t_q, vx_q, vy_q, vor;
	logic signed [DIFF_W-1:0] d_q, p_q, diff, d_abs, p_abs;
	logic                q_neg_q, yneg_q, big;
	logic signed [XY_W-1:0] x_q, y_q, dx, dy, x0;
	logic signed [Z_W-1:0]  z_q, ang;
	logic signed [Z_W:0]    zs, zr;
	logic signed [OUT_W-1:0] sat;

	always_comb begin
		unique case (cmd.sel)
			SEL_N_SXX:  begin opa = MUL_OP_W'(sums.sxx); opb = MUL_OP_W'(sums.hit); end
			SEL_SX_SX:  begin opa = MUL_OP_W'(sums.sx);  opb = MUL_OP_W'(sums.sx);  end
			SEL_N_SXY:  begin opa = MUL_OP_W'(sums.sxy); opb = MUL_OP_W'(sums.hit); end
			SEL_SX_SY:  begin opa = MUL_OP_W'(sums.sx);  opb = MUL_OP_W'(sums.sy);  end
			SEL_SX_SXY: begin opa = MUL_OP_W'(sums.sxy); opb = MUL_OP_W'(sums.sx);  end
			SEL_SXX_SY: begin opa = MUL_OP_W'(sums.sxx); opb = MUL_OP_W'(sums.sy);  end
			default:    begin opa = '0; opb = '0; end
		endcase
		diff  = $signed({1'b0, t_q}) - $signed({1'b0, acc_q});
		d_abs = d_q[DIFF_W-1] ? -d_q : d_q;
		p_abs = p_q[DIFF_W-1] ? -p_q : p_q;
		vor   = vx_q | vy_q;
		big   = |vor[PROD_W-1:NORM_BITS];
		stat.d_zero    = (d_q == '0);
		stat.norm_done = !big && vor[NORM_BITS-1];
		x0  = $signed({{(XY_W-NORM_BITS){1'b0}}, vy_q[NORM_BITS-1:0]});
		dx  = y_q >>> cmd.step;
		dy  = x_q >>> cmd.step;
		ang = $signed({{(Z_W-ANG_W){1'b0}}, atan_q16(cmd.step)});
		zs  = {z_q[Z_W-1], z_q} + (Z_W+1)'(256);
		zr  = zs >>> 9;
		if (zr > (Z_W+1)'(LIMIT_Q7))
			sat = OUT_W'(LIMIT_Q7);
		else if (zr < -(Z_W+1)'(LIMIT_Q7))
			sat = -OUT_W'(LIMIT_Q7);
		else
			sat = zr[OUT_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_load) begin
			ma_q  <= PROD_W'(opa);
			mb_q  <= opb;
			acc_q <= '0;
		end else if (cmd.mul_step) begin
			if (mb_q[0])
				acc_q <= acc_q + ma_q;
			ma_q <= ma_q << 1;
			mb_q <= mb_q >> 1;
		end
		if (cmd.commit) begin
			unique case (cmd.sel)
				SEL_SX_SX:  d_q <= diff;
				SEL_SX_SY:  p_q <= diff;
				SEL_SXX_SY: q_neg_q <= diff[DIFF_W-1];
				default:    t_q <= acc_q;
			endcase
		end
		if (cmd.prep) begin
			vx_q   <= d_abs[PROD_W-1:0];
			vy_q   <= p_abs[PROD_W-1:0];
			yneg_q <= q_neg_q ? p_q[DIFF_W-1] : (!p_q[DIFF_W-1] && (p_q != '0));
		end else if (cmd.norm_step) begin
			// truncating shifts compose, so one bit per cycle matches one big shift
			if (big) begin
				vx_q <= vx_q >> 1;
				vy_q <= vy_q >> 1;
			end else begin
				vx_q <= vx_q << 1;
				vy_q <= vy_q << 1;
			end
		end
		if (cmd.cordic_load) begin
			x_q <= $signed({{(XY_W-NORM_BITS){1'b0}}, vx_q[NORM_BITS-1:0]});
			y_q <= yneg_q ? -x0 : x0;
			z_q <= '0;
		end else if (cmd.cordic_step) begin
			if (!y_q[XY_W-1]) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + ang;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - ang;
			end
		end
		if (cmd.emit) begin
			if (stat.d_zero) begin
				angle_deg_q7 <= OUT_W'(LIMIT_Q7);
				degenerate   <= 1'b1;
			end else begin
				angle_deg_q7 <= sat;
				degenerate   <= 1'b0;
			end
		end
	end

endmodule

@@ src/tpla_ctrl.sv @@
// Sequencer for the end-of-frame solve: products, normalization, CORDIC, result strobe.
module tpla_ctrl import tpla_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       frame_end,
	input  tpla_stat_t stat,
	output tpla_cmd_t  cmd,
	output logic       busy,
	output logic       done
);

	typedef enum logic [2:0] {
		S_IDLE, S_LOAD, S_MUL, S_COMMIT, S_PREP, S_NORM, S_CORDIC, S_EMIT
	} state_t;

	state_t            state_q;
	logic [2:0]        k_q;
	logic [5:0]        cnt_q;
	logic [STEP_W-1:0] i_q;
	logic              done_q;

	always_comb begin
		cmd      = '0;
		cmd.sel  = k_q;
		cmd.step = i_q;
		unique case (state_q)
			S_LOAD:   cmd.mul_load = 1'b1;
			S_MUL:    cmd.mul_step = 1'b1;
			S_COMMIT: cmd.commit   = 1'b1;
			S_PREP:   cmd.prep     = !stat.d_zero;
			S_NORM: begin
				cmd.norm_step   = !stat.norm_done;
				cmd.cordic_load = stat.norm_done;
			end
			S_CORDIC: cmd.cordic_step = 1'b1;
			S_EMIT:   cmd.emit = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			cnt_q   <= '0;
			i_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					k_q <= '0;
					if (frame_end)
						state_q <= S_LOAD;
				end
				S_LOAD: begin
					cnt_q   <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(MUL_STEPS - 1))
						state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					k_q <= k_q + 3'd1;
					state_q <= (k_q == SEL_SXX_SY) ? S_PREP : S_LOAD;
				end
				S_PREP: state_q <= stat.d_zero ? S_EMIT : S_NORM;
				S_NORM: begin
					i_q <= '0;
					if (stat.norm_done)
						state_q <= S_CORDIC;
				end
				S_CORDIC: begin
					i_q <= i_q + STEP_W'(1);
					if (i_q == STEP_W'(CORDIC_STEPS - 1))
						state_q <= S_EMIT;
				end
				S_EMIT: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

@@ src/thresholded_pixel_line_fit_angle.sv @@
// Throughput: one pixel per cycle while busy is low; the last pixel of a frame raises busy.
// End-of-frame solve: six 49-step shift-add products, each with a load and a commit state, a
// prep state, normalization shifts, 16 CORDIC steps and an emit state; a zero determinant
// skips normalization and CORDIC and goes straight to emit. done rises as busy falls.
// arst_n clears position, sums and sequencer and restores width 640, height 480, threshold 200.
// The receiver cannot stall: angle_deg_q7 and degenerate are valid only while done is high.
module thresholded_pixel_line_fit_angle import tpla_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [7:0]              red,
	output logic                    done,
	output logic signed [OUT_W-1:0] angle_deg_q7,
	output logic                    degenerate,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [DIM_W-1:0]        cfg_data
);

	tpla_sums_t sums;
	tpla_cmd_t  cmd;
	tpla_stat_t stat;
	logic       frame_end;

	tpla_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_valid (start && !busy),
		.red       (red),
		.clear     (cmd.emit),
		.sums      (sums),
		.frame_end (frame_end)
	);

	tpla_dp u_dp (
		.clk          (clk),
		.sums         (sums),
		.cmd          (cmd),
		.stat         (stat),
		.angle_deg_q7 (angle_deg_q7),
		.degenerate   (degenerate)
	);

	tpla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame_end (frame_end),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done)
	);

endmodule
